@@ hw/rtl/tgad_pkg.sv @@
// Shared types and constants for the TGA true-color stream decoder.
`default_nettype none
package tgad_pkg;

    localparam int DimBits   = 16;
    localparam int HeaderLen = 18;
    localparam int LenBits   = 34;

    // Largest accepted image dimension, one bit wider than the dimension fields.
    localparam logic [16:0] DimMax = 17'((64'd1 << DimBits) - 64'd1);

    // Header byte offsets
    localparam logic [4:0] HdrIdLen     = 5'd0;
    localparam logic [4:0] HdrMapType   = 5'd1;
    localparam logic [4:0] HdrImageType = 5'd2;
    localparam logic [4:0] HdrWidthLo   = 5'd12;
    localparam logic [4:0] HdrWidthHi   = 5'd13;
    localparam logic [4:0] HdrHeightLo  = 5'd14;
    localparam logic [4:0] HdrHeightHi  = 5'd15;
    localparam logic [4:0] HdrDepth     = 5'd16;
    localparam logic [4:0] HdrDesc      = 5'(HeaderLen - 1);

    localparam logic [7:0] ImageTypeTrue = 8'd2;
    localparam logic [7:0] Depth24       = 8'd24;
    localparam logic [7:0] Depth32       = 8'd32;
    localparam logic [7:0] AlphaOpaque   = 8'd255;

    // Faults latched before the descriptor byte
    localparam int FaultMap   = 0;
    localparam int FaultType  = 1;
    localparam int FaultDepth = 2;

    typedef enum logic [2:0] {
        STATUS_OK            = 3'd0,
        STATUS_COLOR_MAP     = 3'd1,
        STATUS_BAD_TYPE      = 3'd2,
        STATUS_BAD_DEPTH     = 3'd3,
        STATUS_ZERO_SIZE     = 3'd4,
        STATUS_RIGHT_TO_LEFT = 3'd5,
        STATUS_INTERLEAVE    = 3'd6,
        STATUS_TRUNCATED     = 3'd7
    } status_t;

    // Header fields handed to the header check
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic        four_byte;
        logic [7:0]  id_len;
        logic [2:0]  early_faults;
    } hdr_info_t;

endpackage
`default_nettype wire

@@ hw/rtl/tgad_header_check.sv @@
// Header validation: size product, fault priority and file length check.
`default_nettype none
module tgad_header_check (
    input  wire logic                         aclk,
    input  wire logic                         load_product,
    input  wire tgad_pkg::hdr_info_t          info,
    input  wire logic [7:0]                   desc,
    input  wire logic [tgad_pkg::LenBits-1:0] file_length,
    output tgad_pkg::status_t                 status
);

    logic [31:0] product_reg;
    logic [33:0] need_bytes;
    logic [8:0]  overhead;
    logic [34:0] need_total;
    logic        size_fault;
    logic        short_file;

    // Width and height are final once the depth byte arrives; register the product then.
    always_ff @(posedge aclk) begin
        if (load_product) begin
            product_reg <= {16'd0, info.width} * {16'd0, info.height};
        end
    end

    always_comb begin
        if (info.four_byte) begin
            need_bytes = {product_reg, 2'b00};
        end else begin
            need_bytes = {1'b0, product_reg, 1'b0} + {2'b00, product_reg};
        end
        overhead   = {1'b0, info.id_len} + 9'(tgad_pkg::HeaderLen);
        need_total = {1'b0, need_bytes} + {26'd0, overhead};
        short_file = {1'b0, file_length} < need_total;
        size_fault = (info.width == 16'd0) || (info.height == 16'd0) ||
                     ({1'b0, info.width} > tgad_pkg::DimMax) ||
                     ({1'b0, info.height} > tgad_pkg::DimMax);
    end

    // Lowest fault code wins
    always_comb begin
        if (info.early_faults[tgad_pkg::FaultMap]) begin
            status = tgad_pkg::STATUS_COLOR_MAP;
        end else if (info.early_faults[tgad_pkg::FaultType]) begin
            status = tgad_pkg::STATUS_BAD_TYPE;
        end else if (info.early_faults[tgad_pkg::FaultDepth]) begin
            status = tgad_pkg::STATUS_BAD_DEPTH;
        end else if (size_fault) begin
            status = tgad_pkg::STATUS_ZERO_SIZE;
        end else if (desc[4]) begin
            status = tgad_pkg::STATUS_RIGHT_TO_LEFT;
        end else if (desc[7:6] != 2'b00) begin
            status = tgad_pkg::STATUS_INTERLEAVE;
        end else if (short_file) begin
            status = tgad_pkg::STATUS_TRUNCATED;
        end else begin
            status = tgad_pkg::STATUS_OK;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tga_truecolor_stream_decoder_unit.sv @@
// TGA uncompressed true-color stream decoder, top level.
//
// Usage: stream a TGA file one byte per item on the s_ channel, with
// s_end_of_file set on its final byte. The 18-byte header is parsed, the ID
// field is skipped, and each BGR or BGRA file pixel comes out on the m_
// channel as one RGBA item with its column and top-down row. A header fault
// or an early end mark yields one error item (m_is_pixel low, final_res
// high); the remaining bytes up to the end mark give no items.
// Program file_length over the APB port before the file is streamed; it is
// used when the descriptor byte (the last header byte) is checked.
// Throughput: one byte per cycle, sustained while m_ready is high. Every byte is
// handled in the cycle it is accepted; its result is registered at that clock edge
// and sits in the output register in the next cycle. The pixel size product is
// registered on the depth byte so the length compare at the descriptor byte stays short.
// Stall: while a result waits and m_ready is low, s_ready is low; when
// m_ready is high a new byte is taken in the same cycle the result leaves.
// Reset: aresetn (synchronous, active low) returns to header parsing, clears
// file_length and empties the output register.
`default_nettype none
module tga_truecolor_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_file,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_pixel,
    output logic [2:0]       m_status,
    output logic [15:0]      m_column,
    output logic [15:0]      m_row,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha,
    output logic             m_final_res,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_IDSKIP = 2'd1,
        PH_PIXELS = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  id_left_reg, id_left_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        four_reg, four_next;
    logic        top_reg, top_next;
    logic [2:0]  faults_reg, faults_next;
    logic [1:0]  bip_reg, bip_next;
    logic [2:0][7:0] part_reg, part_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] frow_reg, frow_next;
    logic [tgad_pkg::LenBits-1:0] flen_reg;

    logic              m_valid_reg;
    logic              m_is_pixel_reg;
    tgad_pkg::status_t m_status_reg;
    logic [15:0]       m_column_reg;
    logic [15:0]       m_row_reg;
    logic [7:0]        m_red_reg, m_green_reg, m_blue_reg, m_alpha_reg;
    logic              m_final_reg;

    logic              res_valid;
    logic              res_pixel;
    tgad_pkg::status_t res_status;
    logic [15:0]       res_column, res_row;
    logic [7:0]        res_red, res_green, res_blue, res_alpha;
    logic              res_final;

    logic                s_fire;
    logic                cfg_write;
    tgad_pkg::hdr_info_t hdr_info;
    tgad_pkg::status_t   hdr_status;
    logic                load_product;
    logic [16:0]         col_inc, frow_inc;
    logic                last_pixel;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[3] == 1'b0);
    assign prdata    = (paddr[3] == 1'b0) ? {30'd0, flen_reg} : 64'd0;

    assign hdr_info.width        = width_reg;
    assign hdr_info.height       = height_reg;
    assign hdr_info.four_byte    = four_reg;
    assign hdr_info.id_len       = id_left_reg;
    assign hdr_info.early_faults = faults_reg;
    assign load_product = s_fire && (phase_reg == PH_HEADER) &&
                          (hdr_idx_reg == tgad_pkg::HdrDepth);

    tgad_header_check u_hdr_check (
        .aclk         (aclk),
        .load_product (load_product),
        .info         (hdr_info),
        .desc         (s_data_byte),
        .file_length  (flen_reg),
        .status       (hdr_status)
    );

    assign col_inc    = {1'b0, col_reg} + 17'd1;
    assign frow_inc   = {1'b0, frow_reg} + 17'd1;
    assign last_pixel = (col_inc >= {1'b0, width_reg}) && (frow_inc >= {1'b0, height_reg});

    always_comb begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        id_left_next = id_left_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        four_next    = four_reg;
        top_next     = top_reg;
        faults_next  = faults_reg;
        bip_next     = bip_reg;
        part_next    = part_reg;
        col_next     = col_reg;
        frow_next    = frow_reg;

        res_valid  = 1'b0;
        res_pixel  = 1'b0;
        res_status = tgad_pkg::STATUS_OK;
        res_column = 16'd0;
        res_row    = 16'd0;
        res_red    = 8'd0;
        res_green  = 8'd0;
        res_blue   = 8'd0;
        res_alpha  = 8'd0;
        res_final  = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                case (hdr_idx_reg)
                    tgad_pkg::HdrIdLen: id_left_next = s_data_byte;
                    tgad_pkg::HdrMapType: begin
                        if (s_data_byte != 8'd0) begin
                            faults_next[tgad_pkg::FaultMap] = 1'b1;
                        end
                    end
                    tgad_pkg::HdrImageType: begin
                        if (s_data_byte != tgad_pkg::ImageTypeTrue) begin
                            faults_next[tgad_pkg::FaultType] = 1'b1;
                        end
                    end
                    tgad_pkg::HdrWidthLo:  width_next[7:0]   = s_data_byte;
                    tgad_pkg::HdrWidthHi:  width_next[15:8]  = s_data_byte;
                    tgad_pkg::HdrHeightLo: height_next[7:0]  = s_data_byte;
                    tgad_pkg::HdrHeightHi: height_next[15:8] = s_data_byte;
                    tgad_pkg::HdrDepth: begin
                        four_next = (s_data_byte == tgad_pkg::Depth32);
                        if (s_data_byte != tgad_pkg::Depth24 &&
                            s_data_byte != tgad_pkg::Depth32) begin
                            faults_next[tgad_pkg::FaultDepth] = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (hdr_idx_reg >= tgad_pkg::HdrDesc) begin
                    top_next = s_data_byte[5];
                    if (hdr_status != tgad_pkg::STATUS_OK) begin
                        res_valid  = 1'b1;
                        res_status = hdr_status;
                        res_final  = 1'b1;
                        phase_next = PH_DRAIN;
                    end else if (id_left_reg != 8'd0) begin
                        phase_next = PH_IDSKIP;
                    end else begin
                        phase_next = PH_PIXELS;
                    end
                end else begin
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                end
            end
            PH_IDSKIP: begin
                if (id_left_reg != 8'd0) begin
                    id_left_next = id_left_reg - 8'd1;
                end
                if (id_left_next == 8'd0) begin
                    phase_next = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (bip_reg != 2'd3) begin
                    part_next[bip_reg] = s_data_byte;
                    bip_next = bip_reg + 2'd1;
                end
                // Emit on the third byte at 24 bpp, on the fourth at 32 bpp
                if ((bip_reg == 2'd2 && !four_reg) || bip_reg == 2'd3) begin
                    res_valid  = 1'b1;
                    res_pixel  = 1'b1;
                    res_column = col_reg;
                    res_row    = top_reg ? frow_reg : (height_reg - 16'd1 - frow_reg);
                    res_blue   = part_reg[0];
                    res_green  = part_reg[1];
                    if (bip_reg == 2'd3) begin
                        res_red   = part_reg[2];
                        res_alpha = s_data_byte;
                    end else begin
                        res_red   = s_data_byte;
                        res_alpha = tgad_pkg::AlphaOpaque;
                    end
                    res_final = last_pixel;
                    bip_next  = 2'd0;
                    if (col_inc >= {1'b0, width_reg}) begin
                        col_next  = 16'd0;
                        frow_next = frow_inc[15:0];
                    end else begin
                        col_next = col_inc[15:0];
                    end
                    if (last_pixel) begin
                        phase_next = PH_DRAIN;
                    end
                end
            end
            default: ;
        endcase

        // End mark: report truncation unless the file already finished or ended in a header fault, then restart
        if (s_end_of_file) begin
            if (phase_next != PH_DRAIN) begin
                res_valid  = 1'b1;
                res_pixel  = 1'b0;
                res_status = tgad_pkg::STATUS_TRUNCATED;
                res_column = 16'd0;
                res_row    = 16'd0;
                res_red    = 8'd0;
                res_green  = 8'd0;
                res_blue   = 8'd0;
                res_alpha  = 8'd0;
                res_final  = 1'b1;
            end
            phase_next   = PH_HEADER;
            hdr_idx_next = 5'd0;
            id_left_next = 8'd0;
            width_next   = 16'd0;
            height_next  = 16'd0;
            four_next    = 1'b0;
            top_next     = 1'b0;
            faults_next  = 3'd0;
            bip_next     = 2'd0;
            col_next     = 16'd0;
            frow_next    = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= 5'd0;
            id_left_reg <= 8'd0;
            width_reg   <= 16'd0;
            height_reg  <= 16'd0;
            four_reg    <= 1'b0;
            top_reg     <= 1'b0;
            faults_reg  <= 3'd0;
            bip_reg     <= 2'd0;
            col_reg     <= 16'd0;
            frow_reg    <= 16'd0;
            flen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                flen_reg <= pwdata[tgad_pkg::LenBits-1:0];
            end
            if (s_fire) begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                id_left_reg <= id_left_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                four_reg    <= four_next;
                top_reg     <= top_next;
                faults_reg  <= faults_next;
                bip_reg     <= bip_next;
                col_reg     <= col_next;
                frow_reg    <= frow_next;
                m_valid_reg <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            part_reg <= part_next;
        end
        if (s_fire && res_valid) begin
            m_is_pixel_reg <= res_pixel;
            m_status_reg   <= res_status;
            m_column_reg   <= res_column;
            m_row_reg      <= res_row;
            m_red_reg      <= res_red;
            m_green_reg    <= res_green;
            m_blue_reg     <= res_blue;
            m_alpha_reg    <= res_alpha;
            m_final_reg    <= res_final;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_pixel  = m_is_pixel_reg;
    assign m_status    = m_status_reg;
    assign m_column    = m_column_reg;
    assign m_row       = m_row_reg;
    assign m_red       = m_red_reg;
    assign m_green     = m_green_reg;
    assign m_blue      = m_blue_reg;
    assign m_alpha     = m_alpha_reg;
    assign m_final_res = m_final_reg;

endmodule
`default_nettype wire

@@ hw/rtl/tgad_checker.sv @@
// Port-level assertions for the TGA decoder, bound to the top level.
`default_nettype none
module tgad_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_is_pixel,
    input wire logic [2:0]  m_status,
    input wire logic [15:0] m_column,
    input wire logic [15:0] m_row,
    input wire logic [7:0]  m_red,
    input wire logic [7:0]  m_green,
    input wire logic [7:0]  m_blue,
    input wire logic [7:0]  m_alpha,
    input wire logic        m_final_res
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_pixel) && $stable(m_status) &&
            $stable(m_column) && $stable(m_row) && $stable(m_red) && $stable(m_green) &&
            $stable(m_blue) && $stable(m_alpha) && $stable(m_final_res))
        else $error("stalled result changed");

    // Error items are final, nonzero status, empty pixel fields
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_pixel |-> m_final_res && m_status != tgad_pkg::STATUS_OK &&
            m_column == 16'd0 && m_row == 16'd0 && m_red == 8'd0 && m_green == 8'd0 &&
            m_blue == 8'd0 && m_alpha == 8'd0)
        else $error("malformed error item");

    a_pixel_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_pixel |-> m_status == tgad_pkg::STATUS_OK)
        else $error("pixel item with nonzero status");

    // An empty output register never blocks input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind tga_truecolor_stream_decoder_unit tgad_checker u_tgad_checker (.*);
`default_nettype wire

@@ tb/sv/tga_pixel_checker.sv @@
// Checker that predicts the decoder's pixel and error items and compares them with the output.
`timescale 1ns / 100ps
module tga_pixel_checker #(
    parameter logic [3:0] LEN_ADDR = 4'd0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_file,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_is_pixel,
    input  wire logic [2:0]  m_status,
    input  wire logic [15:0] m_column,
    input  wire logic [15:0] m_row,
    input  wire logic [7:0]  m_red,
    input  wire logic [7:0]  m_green,
    input  wire logic [7:0]  m_blue,
    input  wire logic [7:0]  m_alpha,
    input  wire logic        m_final_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output int               fail_count,
    output int               outstanding
);
    import tgad_pkg::*;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_ID,
        PARSE_PIXELS,
        PARSE_DRAIN
    } parse_t;

    typedef struct packed {
        logic        is_pixel;
        status_t     status;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        final_res;
    } decoded_t;

    logic [33:0] file_len = '0;
    parse_t      parse = PARSE_HEADER;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_left;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        wide_px;
    logic        top_down;
    logic        f_map, f_type, f_depth, f_size, f_rtl, f_ilv;
    logic [1:0]  px_byte;
    logic [23:0] px_acc;
    int unsigned col_ctr;
    int unsigned row_ctr;

    decoded_t decoded_q[$];
    decoded_t want;
    decoded_t next_res;
    bit       has_res;
    int       mismatch_count = 0;

    task automatic clear_stream();
        parse    = PARSE_HEADER;
        hdr_pos  = '0;
        id_left  = '0;
        img_w    = '0;
        img_h    = '0;
        wide_px  = 1'b0;
        top_down = 1'b0;
        {f_map, f_type, f_depth, f_size, f_rtl, f_ilv} = '0;
        px_byte  = '0;
        px_acc   = '0;
        col_ctr  = 0;
        row_ctr  = 0;
    endtask

    function automatic decoded_t error_item(input status_t st);
        decoded_t r;
        r           = '0;
        r.status    = st;
        r.final_res = 1'b1;
        return r;
    endfunction

    // Latch the descriptor faults, then report the lowest fault or a short file.
    task automatic check_header(input logic [7:0] desc, output status_t st);
        logic [63:0] need;
        if (img_w == 0 || img_h == 0 || img_w > DimMax || img_h > DimMax)
            f_size = 1'b1;
        if (desc[4])
            f_rtl = 1'b1;
        if (desc[7:6] != 2'b00)
            f_ilv = 1'b1;
        top_down = desc[5];
        need = 64'(img_w) * 64'(img_h) * (wide_px ? 64'd4 : 64'd3);
        if (f_map)
            st = STATUS_COLOR_MAP;
        else if (f_type)
            st = STATUS_BAD_TYPE;
        else if (f_depth)
            st = STATUS_BAD_DEPTH;
        else if (f_size)
            st = STATUS_ZERO_SIZE;
        else if (f_rtl)
            st = STATUS_RIGHT_TO_LEFT;
        else if (f_ilv)
            st = STATUS_INTERLEAVE;
        else if (64'(file_len) < need + 64'(HeaderLen) + 64'(id_left))
            st = STATUS_TRUNCATED;
        else
            st = STATUS_OK;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eof,
                               output bit got, output decoded_t r);
        status_t    st;
        logic [7:0] alpha_v;
        bit         emit_px;
        bit         last;
        got     = 1'b0;
        r       = '0;
        emit_px = 1'b0;
        alpha_v = AlphaOpaque;
        case (parse)
            PARSE_HEADER: begin
                case (hdr_pos)
                    HdrIdLen:     id_left = b;
                    HdrMapType:   if (b != 8'd0) f_map = 1'b1;
                    HdrImageType: if (b != ImageTypeTrue) f_type = 1'b1;
                    HdrWidthLo:   img_w[7:0] = b;
                    HdrWidthHi:   img_w[15:8] = b;
                    HdrHeightLo:  img_h[7:0] = b;
                    HdrHeightHi:  img_h[15:8] = b;
                    HdrDepth: begin
                        wide_px = (b == Depth32);
                        if (b != Depth24 && b != Depth32)
                            f_depth = 1'b1;
                    end
                    default: ;
                endcase
                if (hdr_pos == HdrDesc) begin
                    check_header(b, st);
                    if (st != STATUS_OK) begin
                        r     = error_item(st);
                        got   = 1'b1;
                        parse = PARSE_DRAIN;
                    end else begin
                        parse = (id_left != 0) ? PARSE_ID : PARSE_PIXELS;
                    end
                end else begin
                    hdr_pos++;
                end
            end
            PARSE_ID: begin
                if (id_left != 0)
                    id_left--;
                if (id_left == 0)
                    parse = PARSE_PIXELS;
            end
            PARSE_PIXELS: begin
                // File order is B, G, R, then A at 32 bpp
                if (px_byte < 2'd3) begin
                    px_acc  = px_acc | (24'(b) << (8 * px_byte));
                    px_byte++;
                    emit_px = (px_byte == 2'd3) && !wide_px;
                end else begin
                    alpha_v = b;
                    emit_px = 1'b1;
                end
                if (emit_px) begin
                    last = (col_ctr + 1 >= img_w) && (row_ctr + 1 >= img_h);
                    r.is_pixel  = 1'b1;
                    r.status    = STATUS_OK;
                    r.column    = col_ctr[15:0];
                    r.row       = top_down ? row_ctr[15:0]
                                           : 16'(32'(img_h) - 32'd1 - row_ctr);
                    r.red       = px_acc[23:16];
                    r.green     = px_acc[15:8];
                    r.blue      = px_acc[7:0];
                    r.alpha     = alpha_v;
                    r.final_res = last;
                    got         = 1'b1;
                    px_byte     = '0;
                    px_acc      = '0;
                    col_ctr++;
                    if (col_ctr >= img_w) begin
                        col_ctr = 0;
                        row_ctr++;
                    end
                    if (last)
                        parse = PARSE_DRAIN;
                end
            end
            default: ;
        endcase
        // End mark before the image is complete, with no header fault reported, replaces whatever this byte made
        if (eof) begin
            if (parse != PARSE_DRAIN) begin
                r   = error_item(STATUS_TRUNCATED);
                got = 1'b1;
            end
            clear_stream();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            file_len = '0;
            clear_stream();
            decoded_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
                file_len = pwdata[33:0];
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result item with no prediction: is_pixel %0b status %0d",
                           m_is_pixel, m_status);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("is_pixel", want.is_pixel, m_is_pixel);
                    check_field("status", want.status, m_status);
                    check_field("column", want.column, m_column);
                    check_field("row", want.row, m_row);
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("alpha", want.alpha, m_alpha);
                    check_field("final_res", want.final_res, m_final_res);
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_end_of_file, has_res, next_res);
                if (has_res)
                    decoded_q.push_back(next_res);
            end
        end
        outstanding <= decoded_q.size();
        fail_count  <= mismatch_count;
    end

endmodule

@@ tb/sv/tga_truecolor_stream_decoder_unit_test.sv @@
// Testbench top: streams TGA files and file_length writes into the decoder and gives the verdict.
`timescale 1ns / 100ps
module tga_truecolor_stream_decoder_unit_test;
    import tgad_pkg::*;

    localparam logic [3:0]  RegFileLength   = 4'd0;
    localparam logic [33:0] FileLengthMax   = 34'h3_FFFF_FFFF;
    localparam logic [7:0]  DescTopOrigin   = 8'h20;
    localparam logic [7:0]  DescRightToLeft = 8'h10;
    localparam int          IdleLimit       = 2000;
    localparam int          SettleCycles    = 4;
    localparam int          TargetBytes     = 1300;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = '0;
    logic        s_end_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_is_pixel;
    logic [2:0]  m_status;
    logic [15:0] m_column;
    logic [15:0] m_row;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic        m_final_res;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [63:0] pwdata        = '0;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;

    logic [7:0] file_bytes[$];

    tga_truecolor_stream_decoder_unit uut (.*);

    tga_pixel_checker #(.LEN_ADDR(RegFileLength)) u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                idle_pct  = 66;
                stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct <= 66;
            end
            IDLE_BOTH: begin
                idle_pct  = 7;
                stall_pct <= 7;
            end
            default: begin
                idle_pct  = 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Hold the sender until every predicted item is out and the pipe is quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_file_length(input logic [33:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RegFileLength;
        pwdata  <= 64'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic build_file(input logic [7:0] id_len, input logic [7:0] map,
                              input logic [7:0] itype, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth,
                              input logic [7:0] desc, input int body_len);
        file_bytes.delete();
        file_bytes.push_back(id_len);
        file_bytes.push_back(map);
        file_bytes.push_back(itype);
        repeat (9) file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(depth);
        file_bytes.push_back(desc);
        repeat (int'(id_len) + body_len) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic cut_file(input int keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endtask

    function automatic int pixel_bytes(input logic [15:0] w, input logic [15:0] h,
                                       input logic [7:0] depth);
        return int'(w) * int'(h) * ((depth == Depth32) ? 4 : 3);
    endfunction

    initial begin : stimulus
        logic [7:0]  id_len, map, itype, depth, desc;
        logic [15:0] w, h;
        int          body, roll, phase_idx;

        set_idle(IDLE_NONE);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed files
        write_file_length(FileLengthMax);
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, 8'h00, 3);
        send_file();
        // top-left origin, ID field, bytes after the last pixel
        build_file(2, 0, ImageTypeTrue, 2, 2, Depth32, DescTopOrigin | 8'h08, 16 + 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 3, 2, Depth24, 8'h00, 18);
        send_file();
        // color map and bad type together: the lower code wins
        build_file(0, 1, 8'd10, 1, 1, Depth24, 8'h00, 5);
        send_file();
        build_file(0, 0, 8'd10, 1, 1, Depth24, 8'h00, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 1, 8'd16, 8'h00, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 0, 1, Depth24, 8'h00, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 0, Depth24, 8'h00, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, DescRightToLeft, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, 8'h40, 3);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth32, 8'h80, 4);
        send_file();
        // end mark inside the header
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, 8'h00, 3);
        cut_file(10);
        send_file();
        // end mark on the descriptor byte, with and without a fault there
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, DescRightToLeft, 3);
        cut_file(HeaderLen);
        send_file();
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, 8'h00, 3);
        cut_file(HeaderLen);
        send_file();
        // end mark inside the ID field
        build_file(5, 0, ImageTypeTrue, 1, 1, Depth24, 8'h00, 3);
        cut_file(20);
        send_file();
        // end mark on a completed pixel that is not the last
        build_file(0, 0, ImageTypeTrue, 2, 1, Depth24, 8'h00, 6);
        cut_file(HeaderLen + 3);
        send_file();
        // widest image, longest ID field: two pixels, then a short stop
        build_file(255, 0, ImageTypeTrue, 16'hFFFF, 16'hFFFF, Depth32, 8'h00, 9);
        send_file();
        // file length exactly enough, then one byte short, then zero
        write_file_length(34'(HeaderLen + 1 + 6));
        build_file(1, 0, ImageTypeTrue, 2, 1, Depth24, 8'h00, 6);
        send_file();
        write_file_length(34'(HeaderLen + 1 + 6 - 1));
        build_file(1, 0, ImageTypeTrue, 2, 1, Depth24, 8'h00, 6);
        send_file();
        write_file_length('0);
        build_file(0, 0, ImageTypeTrue, 1, 1, Depth24, 8'h00, 3);
        send_file();

        // Random files, grouped in phases of one idle mode and one file length
        phase_idx = 0;
        while (bytes_sent < TargetBytes) begin
            case ($urandom_range(9))
                0:       write_file_length('0);
                1, 2, 3: write_file_length({2'($urandom_range(3)), 32'($urandom)});
                4, 5:    write_file_length(34'($urandom_range(120, 18)));
                default: write_file_length(FileLengthMax);
            endcase
            set_idle(idle_mode_t'(phase_idx % 4));
            repeat (6) begin
                w = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 5))
                                             : 16'($urandom_range(4, 1));
                h = (w > 16'd4) ? 16'd1 : 16'($urandom_range(4, 1));
                depth = $urandom_range(1) ? Depth32 : Depth24;
                desc  = ($urandom_range(1) ? DescTopOrigin : 8'h00) | 8'($urandom_range(15));
                map   = 8'h00;
                itype = ImageTypeTrue;
                case ($urandom_range(49))
                    0:             id_len = 8'd255;
                    1, 2, 3, 4, 5,
                    6, 7, 8, 9, 10,
                    11, 12:        id_len = 8'($urandom_range(6, 1));
                    default:       id_len = 8'd0;
                endcase
                body = pixel_bytes(w, h, depth);
                roll = $urandom_range(99);
                if (roll < 65) begin
                    if ($urandom_range(3) == 0)
                        body += $urandom_range(5, 1);
                    build_file(id_len, map, itype, w, h, depth, desc, body);
                end else if (roll < 80) begin
                    case ($urandom_range(5))
                        0: map = 8'($urandom_range(255, 1));
                        1: do itype = 8'($urandom_range(255)); while (itype == ImageTypeTrue);
                        2: do depth = 8'($urandom_range(255));
                           while (depth == Depth24 || depth == Depth32);
                        3: if ($urandom_range(1)) w = '0; else h = '0;
                        4: desc |= DescRightToLeft;
                        default: desc |= 8'($urandom_range(3, 1)) << 6;
                    endcase
                    // sometimes stack a second fault
                    if ($urandom_range(3) == 0)
                        desc |= DescRightToLeft;
                    build_file(id_len, map, itype, w, h, depth, desc, $urandom_range(8));
                end else if (roll < 92) begin
                    build_file(id_len, map, itype, w, h, depth, desc, body);
                    cut_file($urandom_range(file_bytes.size() - 1, 1));
                end else begin
                    file_bytes.delete();
                    repeat ($urandom_range(40, 1))
                        file_bytes.push_back(8'($urandom_range(255)));
                end
                send_file();
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
            phase_idx++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
